[rtl/pme_pkg.sv]
`timescale 1ns / 1ps
package pme_pkg;

  localparam logic [31:0] SYNC_WORD   = 32'h7CD2_15D8;
  localparam logic [31:0] IDLE_WORD   = 32'h7A89_C197;
  localparam logic [31:0] BCH_GEN     = 32'hED20_0000;
  localparam logic [31:0] TOP_BIT     = 32'h8000_0000;
  localparam logic [4:0]  BATCH_LIMIT = 5'd16;
  localparam logic [4:0]  INFO_BITS   = 5'd21;
  localparam logic [4:0]  WORD_BITS   = 5'd20;
  localparam logic [3:0]  SPACE_CODE  = 4'h3;
  localparam logic [3:0]  LAST_SLOT   = 4'd15;
  localparam logic [5:0]  IDLEB_LEN   = 6'd16;
  localparam logic [5:0]  MASS_SYNC2  = 6'd17;
  localparam logic [5:0]  MASS_LEN    = 6'd33;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_NUM   = 2'd1,
    MODE_ALPHA = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEAL, ST_START, ST_FEED, ST_PAD,
    ST_FILL, ST_PLACE, ST_MASS, ST_IDLEB, ST_FLUSH
  } state_t;

  // Numeric character to bit-reversed 4-bit code.
  function automatic logic [3:0] numeric_code(input logic [7:0] c);
    logic [3:0] v;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if (c == 8'h55) v = 4'hB;
    else if (c == 8'h20) v = 4'hC;
    else if (c == 8'h2D) v = 4'hD;
    else if (c == 8'h29) v = 4'hE;
    else if (c == 8'h28) v = 4'hF;
    else v = 4'hC;
    return {v[0], v[1], v[2], v[3]};
  endfunction

endpackage

[rtl/pocsag_message_encoder.sv]
`timescale 1ns / 1ps
// Channel  | Ports                                               | Direction
// input    | in_valid/in_ready, in_operation .. in_last          | request in
// result   | out_valid/out_ready, out_codeword, out_last_res,    | request out
//          | out_truncated                                       |
// config   | cfg_we, cfg_wdata (max_batches)                     | write only
// One item is taken at a time; in_ready is high only while the sequencer idles.
// Each check word uses the shared BCH divider, one bit a cycle. A final item also adds
// padding, an alphanumeric terminator and idle fill. Results pass through a one-word
// hold and an output register; a stalled out_ready stops the sequencer without losing
// words. rst_n is synchronous.
module pocsag_message_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [20:0] in_address,
  input  logic [1:0]  in_function_code,
  input  logic [1:0]  in_message_kind,
  input  logic        in_mass_send,
  input  logic [7:0]  in_character,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_codeword,
  output logic        out_last_res,
  output logic        out_truncated,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);
  import pme_pkg::*;

  state_t      state_r, state_nxt, wret_r, wret_nxt;
  mode_t       mode_r, mode_nxt;
  logic [4:0]  maxb_r, maxb_nxt;
  logic [3:0]  slot_r, slot_nxt;
  logic [4:0]  batch_r, batch_nxt;
  logic [19:0] acc_r, acc_nxt;
  logic [4:0]  bcnt_r, bcnt_nxt;
  logic [31:0] held_r, held_nxt;
  logic [31:0] msg_r, msg_nxt;
  logic        massp_r, massp_nxt, massf_r, massf_nxt;
  logic        ovf_r, ovf_nxt, first_r, first_nxt;
  logic        fin_r, fin_nxt, term_r, term_nxt, mark_r, mark_nxt;
  logic        ret_word_r, ret_word_nxt;
  logic [2:0]  frm_r, frm_nxt;
  logic [6:0]  feed_r, feed_nxt;
  logic [2:0]  left_r, left_nxt;
  logic [5:0]  seq_r, seq_nxt;
  logic [31:0] sw_r, sw_nxt, sr_r, sr_nxt;
  logic [4:0]  scnt_r, scnt_nxt;
  logic [31:0] hold_r, hold_nxt;
  logic        hold_v_r, hold_v_nxt, hold_t_r, hold_t_nxt;
  logic        ov_r, ov_nxt, ol_r, ol_nxt, ot_r, ot_nxt;
  logic [31:0] ow_r, ow_nxt;

  logic        out_free, can_emit, emit_en;
  logic [31:0] emit_word, sealed_v, sealed, word_in;
  logic [4:0]  lim, ncnt;
  logic [19:0] nacc;
  logic [3:0]  nslot;
  logic [5:0]  start_end;

  // Effective batch limit.
  always_comb begin
    if (maxb_r == 5'd0) lim = 5'd1;
    else if (maxb_r > BATCH_LIMIT) lim = BATCH_LIMIT;
    else lim = maxb_r;
  end

  assign out_free  = !ov_r || out_ready;
  assign can_emit  = !hold_v_r || out_free;
  assign sealed_v  = sw_r | (sr_r >> 21);
  assign sealed    = {sealed_v[31:1], sealed_v[0] | (^sealed_v)};
  assign word_in   = TOP_BIT | {1'b0, nacc, 11'd0};
  assign nslot     = slot_r + 4'd1;
  assign start_end = {2'd0, frm_r, 1'b1};
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_codeword  = ow_r;
  assign out_last_res  = ol_r;
  assign out_truncated = ot_r;

  // Sequencer: next state, datapath and emission.
  always_comb begin
    state_nxt = state_r; wret_nxt = wret_r; mode_nxt = mode_r; maxb_nxt = maxb_r;
    slot_nxt = slot_r; batch_nxt = batch_r; acc_nxt = acc_r; bcnt_nxt = bcnt_r;
    held_nxt = held_r; msg_nxt = msg_r; massp_nxt = massp_r; massf_nxt = massf_r;
    ovf_nxt = ovf_r; first_nxt = first_r; fin_nxt = fin_r; term_nxt = term_r;
    mark_nxt = mark_r; ret_word_nxt = ret_word_r; frm_nxt = frm_r;
    feed_nxt = feed_r; left_nxt = left_r; seq_nxt = seq_r;
    sw_nxt = sw_r; sr_nxt = sr_r; scnt_nxt = scnt_r;
    hold_nxt = hold_r; hold_v_nxt = hold_v_r; hold_t_nxt = hold_t_r;
    ov_nxt = ov_r; ol_nxt = ol_r; ot_nxt = ot_r; ow_nxt = ow_r;
    emit_en = 1'b0; emit_word = IDLE_WORD;
    nacc = acc_r; ncnt = bcnt_r;

    if (cfg_we) maxb_nxt = cfg_wdata;
    if (ov_r && out_ready) ov_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mark_nxt = 1'b0; fin_nxt = in_last; term_nxt = 1'b0;
          if (!in_operation) begin
            acc_nxt = '0; bcnt_nxt = '0; ovf_nxt = 1'b0; massp_nxt = 1'b0;
            first_nxt = 1'b1; slot_nxt = '0; batch_nxt = '0; seq_nxt = '0;
            if (in_message_kind != MODE_NUM && in_message_kind != MODE_ALPHA) begin
              mode_nxt = MODE_NONE;
              state_nxt = ST_IDLEB;
            end else begin
              mode_nxt = mode_t'(in_message_kind);
              massf_nxt = in_mass_send;
              frm_nxt = in_address[2:0];
              sw_nxt = {1'b0, in_address[20:3], in_function_code, 11'd0};
              sr_nxt = {1'b0, in_address[20:3], in_function_code, 11'd0};
              scnt_nxt = '0; ret_word_nxt = 1'b0;
              state_nxt = ST_SEAL;
            end
          end else if (mode_r != MODE_NONE) begin
            if (mode_r == MODE_ALPHA) begin
              feed_nxt = in_character[6:0]; left_nxt = 3'd7;
            end else begin
              feed_nxt = {3'd0, numeric_code(in_character)}; left_nxt = 3'd1;
            end
            state_nxt = ST_FEED;
          end
        end
      end

      // Shared BCH divider: one bit per cycle, then dispatch on the result.
      ST_SEAL: begin
        if (scnt_r != INFO_BITS) begin
          sr_nxt = (sr_r[31] ? (sr_r ^ BCH_GEN) : sr_r) << 1;
          scnt_nxt = scnt_r + 5'd1;
        end else if (!ret_word_r) begin
          held_nxt = sealed;
          if (massf_r) begin
            massp_nxt = 1'b1; left_nxt = '0; state_nxt = ST_FEED;
          end else begin
            seq_nxt = '0; state_nxt = ST_START;
          end
        end else begin
          msg_nxt = sealed; acc_nxt = '0; bcnt_nxt = '0; first_nxt = 1'b0;
          seq_nxt = '0;
          if (massp_r) begin
            massp_nxt = 1'b0; state_nxt = ST_MASS;
          end else begin
            state_nxt = ST_PLACE;
          end
        end
      end

      // Sync word, idle words up to the pager's frame, then the address word.
      ST_START: begin
        if (can_emit) begin
          emit_en = 1'b1;
          if (seq_r == '0) emit_word = SYNC_WORD;
          else if (seq_r == start_end) emit_word = held_r;
          else emit_word = IDLE_WORD;
          seq_nxt = seq_r + 6'd1;
          if (seq_r == start_end) begin
            batch_nxt = 5'd1; slot_nxt = {frm_r, 1'b0};
            left_nxt = '0; state_nxt = ST_FEED;
          end
        end
      end

      // Pack character bits or a nibble into the word being built.
      ST_FEED: begin
        if (left_r != '0) begin
          left_nxt = left_r - 3'd1;
          if (mode_r != MODE_NONE) begin
            if (mode_r == MODE_NUM) begin
              nacc = {acc_r[15:0], feed_r[3:0]}; ncnt = bcnt_r + 5'd4;
            end else begin
              nacc = {acc_r[18:0], feed_r[0]}; ncnt = bcnt_r + 5'd1;
            end
            acc_nxt = nacc; bcnt_nxt = ncnt;
            feed_nxt = feed_r >> 1;
            if (ncnt >= WORD_BITS) begin
              sw_nxt = word_in; sr_nxt = word_in; scnt_nxt = '0;
              ret_word_nxt = 1'b1; wret_nxt = ST_FEED; state_nxt = ST_SEAL;
            end
          end
        end else if (fin_r && mode_r != MODE_NONE) begin
          if (mode_r == MODE_ALPHA && !term_r) begin
            feed_nxt = '0; left_nxt = 3'd7; term_nxt = 1'b1;
          end else begin
            state_nxt = ST_PAD;
          end
        end else begin
          state_nxt = ST_FLUSH;
        end
      end

      // Pad the final partial word (a numeric message with no word yet gets a full word of spaces).
      ST_PAD: begin
        if (mode_r == MODE_NONE) begin
          state_nxt = ST_FLUSH;
        end else if ((mode_r == MODE_NUM && (bcnt_r != '0 || first_r)) ||
                     (mode_r == MODE_ALPHA && bcnt_r != '0)) begin
          if (mode_r == MODE_NUM) begin
            nacc = {acc_r[15:0], SPACE_CODE}; ncnt = bcnt_r + 5'd4;
          end else begin
            nacc = {acc_r[18:0], 1'b0}; ncnt = bcnt_r + 5'd1;
          end
          acc_nxt = nacc; bcnt_nxt = ncnt;
          if (ncnt >= WORD_BITS) begin
            sw_nxt = word_in; sr_nxt = word_in; scnt_nxt = '0;
            ret_word_nxt = 1'b1; wret_nxt = ST_PAD; state_nxt = ST_SEAL;
          end
        end else begin
          seq_nxt = {2'd0, slot_r} + 6'd1;
          state_nxt = ST_FILL;
        end
      end

      // Idle words to the end of the batch.
      ST_FILL: begin
        if (seq_r < IDLEB_LEN) begin
          if (can_emit) begin
            emit_en = 1'b1; emit_word = IDLE_WORD; seq_nxt = seq_r + 6'd1;
          end
        end else begin
          mode_nxt = MODE_NONE; mark_nxt = 1'b1; state_nxt = ST_FLUSH;
        end
      end

      // Put a message word in the next slot, opening a batch if needed; drop it past the batch limit.
      ST_PLACE: begin
        if (seq_r != '0) begin
          if (can_emit) begin
            emit_en = 1'b1; emit_word = msg_r; slot_nxt = '0; state_nxt = wret_r;
          end
        end else if (ovf_r) begin
          state_nxt = wret_r;
        end else if (slot_r == LAST_SLOT) begin
          if (batch_r >= lim) begin
            ovf_nxt = 1'b1; state_nxt = wret_r;
          end else if (can_emit) begin
            emit_en = 1'b1; emit_word = SYNC_WORD;
            batch_nxt = batch_r + 5'd1; seq_nxt = 6'd1;
          end
        end else if (nslot == LAST_SLOT && batch_r >= lim) begin
          ovf_nxt = 1'b1; state_nxt = wret_r;
        end else if (can_emit) begin
          emit_en = 1'b1; emit_word = msg_r; slot_nxt = nslot; state_nxt = wret_r;
        end
      end

      // Mass send: eight frames of address and first word, then an idle batch.
      ST_MASS: begin
        if (can_emit) begin
          emit_en = 1'b1;
          if (seq_r == '0 || seq_r == MASS_SYNC2) emit_word = SYNC_WORD;
          else if (seq_r < MASS_SYNC2) emit_word = seq_r[0] ? held_r : msg_r;
          else emit_word = IDLE_WORD;
          seq_nxt = seq_r + 6'd1;
          if (seq_r == MASS_LEN) begin
            mode_nxt = MODE_NONE; mark_nxt = 1'b1; state_nxt = wret_r;
          end
        end
      end

      // Idle batch: sync plus sixteen idle words.
      ST_IDLEB: begin
        if (can_emit) begin
          emit_en = 1'b1;
          emit_word = (seq_r == '0) ? SYNC_WORD : IDLE_WORD;
          seq_nxt = seq_r + 6'd1;
          if (seq_r == IDLEB_LEN) begin
            mark_nxt = 1'b1; state_nxt = ST_FLUSH;
          end
        end
      end

      // Release the held word, flagged as final if the message ended.
      ST_FLUSH: begin
        if (!hold_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          ov_nxt = 1'b1; ow_nxt = hold_r; ol_nxt = mark_r; ot_nxt = hold_t_r;
          hold_v_nxt = 1'b0; state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // One word stays held back so that the final one can be flagged.
    if (emit_en) begin
      if (hold_v_r) begin
        ov_nxt = 1'b1; ow_nxt = hold_r; ol_nxt = 1'b0; ot_nxt = hold_t_r;
      end
      hold_nxt = emit_word; hold_v_nxt = 1'b1; hold_t_nxt = ovf_r;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; wret_r <= ST_FEED; mode_r <= MODE_NONE;
      maxb_r <= 5'd4; slot_r <= '0; batch_r <= '0; acc_r <= '0; bcnt_r <= '0;
      held_r <= '0; massp_r <= 1'b0; massf_r <= 1'b0; ovf_r <= 1'b0;
      first_r <= 1'b0; fin_r <= 1'b0; term_r <= 1'b0; mark_r <= 1'b0;
      ret_word_r <= 1'b0; left_r <= '0; seq_r <= '0; scnt_r <= '0;
      hold_v_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; wret_r <= wret_nxt; mode_r <= mode_nxt;
      maxb_r <= maxb_nxt; slot_r <= slot_nxt; batch_r <= batch_nxt;
      acc_r <= acc_nxt; bcnt_r <= bcnt_nxt; held_r <= held_nxt;
      massp_r <= massp_nxt; massf_r <= massf_nxt; ovf_r <= ovf_nxt;
      first_r <= first_nxt; fin_r <= fin_nxt; term_r <= term_nxt;
      mark_r <= mark_nxt; ret_word_r <= ret_word_nxt; left_r <= left_nxt;
      seq_r <= seq_nxt; scnt_r <= scnt_nxt; hold_v_r <= hold_v_nxt;
      ov_r <= ov_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    msg_r <= msg_nxt; frm_r <= frm_nxt; feed_r <= feed_nxt;
    sw_r <= sw_nxt; sr_r <= sr_nxt;
    hold_r <= hold_nxt; hold_t_r <= hold_t_nxt;
    ow_r <= ow_nxt; ol_r <= ol_nxt; ot_r <= ot_nxt;
  end

endmodule
